FILE: src/crmc_pkg.sv
package crmc_pkg;

    // Default geometry: integer pixel coordinates and fractional bits of the circle registers.
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 4;

    // Fixed widths of the channel sums, channel values and means.
    localparam int SUM_W  = 32;
    localparam int CHAN_W = 8;
    localparam int MEAN_W = 8;
    localparam int LANES  = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_div;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_done;
        logic div_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: src/circular_region_mean_color.sv
// Mean colour of the pixels that fall inside a circle.
// Input channel (s_*): one pixel per request with its integer column and row, three 8-bit
// channels and s_frame_end on a frame's last pixel; one pixel per cycle while s_ready is high.
// Configuration channel (cfg_*): writes the centre column, centre row and radius, all
// unsigned fixed point with FRAC_BITS fractional bits; it is always ready. The user must
// write it only while the block is idle; the block does not enforce this.
// Result channel (m_*): one request per frame, raised after the last pixel, carrying the
// three truncated channel means and the count of pixels inside the circle (zeros when no
// pixel counted).
// Timing: pixels pass a three-stage pipeline (offset, square, accumulate). After the last
// pixel the input stalls while the pipeline drains and an 8-step restoring divider runs,
// so a result is loaded once the divider ends and the output register is free; the input
// reopens in the same cycle as the result appears. Most of what a frame adds to its pixels
// is spent in the divider.
// A stalled receiver holds the result in the output register; the next frame is accepted
// meanwhile and waits at its own last pixel until the register is free.
// Reset clears the circle registers, the sums, the count and any pending result.
module circular_region_mean_color #(
    parameter int COORD_BITS = crmc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = crmc_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [crmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS+FRAC_BITS-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [COORD_BITS-1:0]           s_col,
    input  logic [COORD_BITS-1:0]           s_row,
    input  logic [crmc_pkg::CHAN_W-1:0]     s_chan0,
    input  logic [crmc_pkg::CHAN_W-1:0]     s_chan1,
    input  logic [crmc_pkg::CHAN_W-1:0]     s_chan2,
    input  logic                            s_frame_end,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [crmc_pkg::MEAN_W-1:0]     m_mean0,
    output logic [crmc_pkg::MEAN_W-1:0]     m_mean1,
    output logic [crmc_pkg::MEAN_W-1:0]     m_mean2,
    output logic [2*COORD_BITS:0]           m_inside_count
);
    import crmc_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic      s_fire;

    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;

    // Frame sequencing.
    crmc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_frame_end (s_frame_end),
        .s_ready     (s_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    // Distance test, accumulation, division and output register.
    crmc_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_fire         (s_fire),
        .s_col          (s_col),
        .s_row          (s_row),
        .s_chan0        (s_chan0),
        .s_chan1        (s_chan1),
        .s_chan2        (s_chan2),
        .s_frame_end    (s_frame_end),
        .cmd            (cmd),
        .sts            (sts),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_mean0        (m_mean0),
        .m_mean1        (m_mean1),
        .m_mean2        (m_mean2),
        .m_inside_count (m_inside_count)
    );

    // The last pixel of a frame closes the input until its result is loaded.
    a_last_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_frame_end |=> !s_ready)
        else $error("input still open after the last pixel of a frame");

    // A new result only appears while the input is closed for its frame.
    a_result_after_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result raised without a closed frame");

    // An empty circle gives zero means.
    a_empty_means_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_inside_count == '0) |->
            (m_mean0 == '0) && (m_mean1 == '0) && (m_mean2 == '0))
        else $error("non-zero mean with no pixel inside the circle");

endmodule

FILE: src/crmc_ctrl.sv
module crmc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_frame_end,
    output logic                  s_ready,
    input  crmc_pkg::ctrl_sts_t   sts,
    output crmc_pkg::ctrl_cmd_t   cmd
);
    import crmc_pkg::*;

    typedef enum logic [4:0] {
        ST_RUN   = 5'b00001,
        ST_DRAIN = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state: pixels flow in RUN, the frame closes through drain, load, divide and output.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (s_valid && s_frame_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (sts.frame_done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    // Handshake and datapath commands.
    assign s_ready      = (state_reg == ST_RUN);
    assign cmd.load_div = (state_reg == ST_LOAD);
    assign cmd.div_step = (state_reg == ST_DIV);
    assign cmd.load_out = (state_reg == ST_OUT) && sts.out_free;

endmodule

FILE: src/crmc_dp.sv
module crmc_dp #(
    parameter int COORD_BITS = crmc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = crmc_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [crmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS+FRAC_BITS-1:0] cfg_data,
    input  logic                            s_fire,
    input  logic [COORD_BITS-1:0]           s_col,
    input  logic [COORD_BITS-1:0]           s_row,
    input  logic [crmc_pkg::CHAN_W-1:0]     s_chan0,
    input  logic [crmc_pkg::CHAN_W-1:0]     s_chan1,
    input  logic [crmc_pkg::CHAN_W-1:0]     s_chan2,
    input  logic                            s_frame_end,
    input  crmc_pkg::ctrl_cmd_t             cmd,
    output crmc_pkg::ctrl_sts_t             sts,
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic [crmc_pkg::MEAN_W-1:0]     m_mean0,
    output logic [crmc_pkg::MEAN_W-1:0]     m_mean1,
    output logic [crmc_pkg::MEAN_W-1:0]     m_mean2,
    output logic [2*COORD_BITS:0]           m_inside_count
);
    import crmc_pkg::*;

    localparam int REG_W   = COORD_BITS + FRAC_BITS;
    localparam int SQ_W    = 2 * REG_W;
    localparam int D2_W    = SQ_W + 1;
    localparam int TALLY_W = 2 * COORD_BITS + 1;
    localparam int DSOR_W  = TALLY_W + MEAN_W - 1;
    localparam int WIDE_W  = (SUM_W > TALLY_W + MEAN_W) ? SUM_W : TALLY_W + MEAN_W;
    localparam int CNT_W   = $clog2(MEAN_W);

    // Circle registers.
    logic [REG_W-1:0] center_x_reg;
    logic [REG_W-1:0] center_y_reg;
    logic [REG_W-1:0] radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CENTER_X: center_x_reg <= cfg_data;
                CFG_CENTER_Y: center_y_reg <= cfg_data;
                CFG_RADIUS:   radius_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage A: absolute offsets from the centre in fixed point.
    logic [REG_W-1:0]  col_fx;
    logic [REG_W-1:0]  row_fx;
    logic [REG_W-1:0]  dx_next;
    logic [REG_W-1:0]  dy_next;
    logic              a_valid_reg;
    logic              a_last_reg;
    logic [REG_W-1:0]  a_dx_reg;
    logic [REG_W-1:0]  a_dy_reg;
    logic [CHAN_W-1:0] a_chan_reg [LANES];

    assign col_fx  = REG_W'(s_col) << FRAC_BITS;
    assign row_fx  = REG_W'(s_row) << FRAC_BITS;
    assign dx_next = (col_fx >= center_x_reg) ? col_fx - center_x_reg : center_x_reg - col_fx;
    assign dy_next = (row_fx >= center_y_reg) ? row_fx - center_y_reg : center_y_reg - row_fx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_last_reg    <= s_frame_end;
            a_dx_reg      <= dx_next;
            a_dy_reg      <= dy_next;
            a_chan_reg[0] <= s_chan0;
            a_chan_reg[1] <= s_chan1;
            a_chan_reg[2] <= s_chan2;
        end
    end

    // Stage B: squares of the offsets and of the radius.
    logic              b_valid_reg;
    logic              b_last_reg;
    logic [SQ_W-1:0]   b_dx2_reg;
    logic [SQ_W-1:0]   b_dy2_reg;
    logic [SQ_W-1:0]   b_r2_reg;
    logic [CHAN_W-1:0] b_chan_reg [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        b_last_reg <= a_last_reg;
        b_dx2_reg  <= SQ_W'(a_dx_reg) * SQ_W'(a_dx_reg);
        b_dy2_reg  <= SQ_W'(a_dy_reg) * SQ_W'(a_dy_reg);
        b_r2_reg   <= SQ_W'(radius_reg) * SQ_W'(radius_reg);
        for (int k = 0; k < LANES; k++) begin
            b_chan_reg[k] <= a_chan_reg[k];
        end
    end

    // Accumulation: saturating channel sums and pixel tally, cleared when the divider loads.
    logic [D2_W-1:0]    d2;
    logic               in_circle;
    logic [SUM_W-1:0]   sum_reg  [LANES];
    logic [SUM_W-1:0]   sum_next [LANES];
    logic [SUM_W:0]     sum_ext  [LANES];
    logic [TALLY_W-1:0] tally_reg;
    logic [TALLY_W-1:0] tally_next;

    assign d2        = D2_W'(b_dx2_reg) + D2_W'(b_dy2_reg);
    assign in_circle = b_valid_reg && (d2 <= D2_W'(b_r2_reg));

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            sum_ext[k] = (SUM_W + 1)'(sum_reg[k]) + (SUM_W + 1)'(b_chan_reg[k]);
            if (cmd.load_div) begin
                sum_next[k] = '0;
            end else if (in_circle) begin
                sum_next[k] = sum_ext[k][SUM_W] ? {SUM_W{1'b1}} : sum_ext[k][SUM_W-1:0];
            end else begin
                sum_next[k] = sum_reg[k];
            end
        end
        if (cmd.load_div) begin
            tally_next = '0;
        end else if (in_circle && (tally_reg != {TALLY_W{1'b1}})) begin
            tally_next = tally_reg + TALLY_W'(1);
        end else begin
            tally_next = tally_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LANES; k++) begin
                sum_reg[k] <= '0;
            end
            tally_reg <= '0;
        end else begin
            for (int k = 0; k < LANES; k++) begin
                sum_reg[k] <= sum_next[k];
            end
            tally_reg <= tally_next;
        end
    end

    // Restoring divider: one quotient bit per lane per cycle in ST_DIV, overflow checked at load.
    logic [SUM_W-1:0]   rem_reg   [LANES];
    logic [MEAN_W-1:0]  q_reg     [LANES];
    logic               clamp_reg [LANES];
    logic [DSOR_W-1:0]  dsor_reg;
    logic               zero_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TALLY_W-1:0] tally_hold_reg;
    logic               ge        [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            ge[k] = WIDE_W'(rem_reg[k]) >= WIDE_W'(dsor_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_div) begin
            for (int k = 0; k < LANES; k++) begin
                rem_reg[k]   <= sum_reg[k];
                q_reg[k]     <= '0;
                clamp_reg[k] <= WIDE_W'(sum_reg[k]) >= (WIDE_W'(tally_reg) << MEAN_W);
            end
            dsor_reg       <= DSOR_W'(tally_reg) << (MEAN_W - 1);
            zero_reg       <= (tally_reg == '0);
            cnt_reg        <= CNT_W'(MEAN_W - 1);
            tally_hold_reg <= tally_reg;
        end else if (cmd.div_step) begin
            for (int k = 0; k < LANES; k++) begin
                if (ge[k]) begin
                    rem_reg[k] <= rem_reg[k] - SUM_W'(dsor_reg);
                end
                q_reg[k] <= {q_reg[k][MEAN_W-2:0], ge[k]};
            end
            dsor_reg <= dsor_reg >> 1;
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    // Output register.
    logic              m_valid_reg;
    logic [MEAN_W-1:0] mean_sel [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (zero_reg) begin
                mean_sel[k] = '0;
            end else if (clamp_reg[k]) begin
                mean_sel[k] = {MEAN_W{1'b1}};
            end else begin
                mean_sel[k] = q_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_mean0        <= mean_sel[0];
            m_mean1        <= mean_sel[1];
            m_mean2        <= mean_sel[2];
            m_inside_count <= tally_hold_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign sts.frame_done = b_valid_reg && b_last_reg;
    assign sts.div_last   = (cnt_reg == '0);
    assign sts.out_free   = !m_valid_reg || m_ready;

endmodule
